FILE: design/plu_pkg.sv
// ---------------------------------------------------------------------------
// plu_pkg: shared types and constants of the periodic linear upsampler
// Sample widths, ratio-derived widths and the run descriptor that the front
// end hands to the interpolation engine.
// ---------------------------------------------------------------------------
package plu_pkg;

    localparam int NUM_CH      = 3;
    localparam int SAMPLE_W    = 24;
    localparam int DIFF_W      = SAMPLE_W + 1;
    // upsampling ratio, 1 to 32; the shift is floor(log2(RATIO))
    localparam int RATIO       = 8;
    localparam int RATIO_SHIFT = $clog2(RATIO + 1) - 1;
    localparam int K_W         = (RATIO > 1) ? $clog2(RATIO) : 1;
    localparam int ACC_W       = DIFF_W + K_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [DIFF_W-1:0]   t_diff;

    // one run of RATIO rows from base to base + diff
    typedef struct packed {
        t_sample [NUM_CH-1:0] base;
        t_diff   [NUM_CH-1:0] diff;
        logic                 run_end;
        logic                 seq_end;
    } t_run;

    typedef struct packed {
        logic push;
        t_run run;
    } t_q_wr;

    function automatic t_run make_run(
        input t_sample [NUM_CH-1:0] a,
        input t_sample [NUM_CH-1:0] b,
        input logic                 run_end,
        input logic                 seq_end
    );
        t_run r;
        for (int c = 0; c < NUM_CH; c++) begin
            r.base[c] = a[c];
            r.diff[c] = {b[c][SAMPLE_W-1], b[c]} - {a[c][SAMPLE_W-1], a[c]};
        end
        r.run_end = run_end;
        r.seq_end = seq_end;
        return r;
    endfunction

endpackage

FILE: design/periodic_linear_upsampler.sv
// ---------------------------------------------------------------------------
// periodic_linear_upsampler: linear interpolation upsampler, three channels
// Input channel i_valid/o_stall carries one row (x, y, z, is_final); output
// channel o_valid/i_stall carries interpolated rows with run_last and
// sequence_end markers. A transaction completes when valid is high and stall
// is low. The first row of a sequence produces nothing unless it is final;
// then it yields RATIO copies of itself. Each later row produces RATIO rows
// from the previous row, and if final also RATIO rows back to the first row.
// The first result passes through the run queue, the engine's run register
// and the registered output stage. Throughput: one result per cycle while
// the receiver does not stall, from the single interpolation engine stepping
// its accumulator once per result. A two-entry run queue decouples the front
// end, so a row is taken while the previous run is still being emitted.
// Reset (synchronous, active low) clears the stored rows and the run queue.
// When the receiver stalls, the output holds, the engine pauses, and once the
// queue fills the input is stalled too; no result is dropped.
// ---------------------------------------------------------------------------
module periodic_linear_upsampler (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  plu_pkg::t_sample i_sample_x,
    input  plu_pkg::t_sample i_sample_y,
    input  plu_pkg::t_sample i_sample_z,
    input  logic             i_is_final,
    output logic             o_valid,
    input  logic             i_stall,
    output plu_pkg::t_sample o_out_x,
    output plu_pkg::t_sample o_out_y,
    output plu_pkg::t_sample o_out_z,
    output logic             o_run_last,
    output logic             o_sequence_end
);
    import plu_pkg::*;

    t_q_wr q_wr;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    t_run  q_head;

    plu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_sample_x (i_sample_x),
        .i_sample_y (i_sample_y),
        .i_sample_z (i_sample_z),
        .i_is_final (i_is_final),
        .o_wr       (q_wr),
        .i_full     (q_full)
    );

    plu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    plu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (q_head),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_run_last     (o_run_last),
        .o_sequence_end (o_sequence_end)
    );

endmodule

FILE: design/plu_queue.sv
// ---------------------------------------------------------------------------
// plu_queue: run descriptor queue
// Two-entry register queue between the front end and the interpolation
// engine; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
module plu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  plu_pkg::t_q_wr i_wr,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output plu_pkg::t_run  o_head
);
    import plu_pkg::*;

    t_run              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(i_wr.push);
        n_rd_ptr = r_rd_ptr + QPTR_W'(i_pop);
        n_count  = r_count + QCNT_W'(i_wr.push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr_ptr] <= i_wr.run;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr.push && o_full && !i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

FILE: design/plu_front.sv
// ---------------------------------------------------------------------------
// plu_front: input front end
// Accepts rows, keeps the first and previous rows of the sequence and turns
// each row into zero, one or two run descriptors for the queue.
// ---------------------------------------------------------------------------
module plu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  plu_pkg::t_sample i_sample_x,
    input  plu_pkg::t_sample i_sample_y,
    input  plu_pkg::t_sample i_sample_z,
    input  logic             i_is_final,
    output plu_pkg::t_q_wr   o_wr,
    input  logic             i_full
);
    import plu_pkg::*;

    t_sample [NUM_CH-1:0] r_first, n_first;
    t_sample [NUM_CH-1:0] r_prev, n_prev;
    logic                 r_have, n_have;
    logic                 r_pend_valid, n_pend_valid;
    t_run                 r_pend, n_pend;
    t_sample [NUM_CH-1:0] cur;
    logic                 accept;

    assign cur     = {i_sample_z, i_sample_y, i_sample_x};
    assign o_stall = r_pend_valid || i_full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_first      = r_first;
        n_prev       = r_prev;
        n_have       = r_have;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        o_wr.push    = 1'b0;
        o_wr.run     = r_pend;
        if (r_pend_valid) begin
            // second run of a closing row: back to the first row
            if (!i_full) begin
                o_wr.push    = 1'b1;
                n_pend_valid = 1'b0;
            end
        end else if (accept) begin
            n_prev = cur;
            n_have = !i_is_final;
            if (!r_have) begin
                n_first = cur;
                if (i_is_final) begin
                    o_wr.push = 1'b1;
                    o_wr.run  = make_run(cur, cur, 1'b1, 1'b1);
                end
            end else begin
                o_wr.push = 1'b1;
                o_wr.run  = make_run(r_prev, cur, !i_is_final, 1'b0);
                if (i_is_final) begin
                    n_pend_valid = 1'b1;
                    n_pend       = make_run(cur, r_first, 1'b1, 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first      <= '0;
            r_prev       <= '0;
            r_have       <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_first      <= n_first;
            r_prev       <= n_prev;
            r_have       <= n_have;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

FILE: design/plu_back.sv
// ---------------------------------------------------------------------------
// plu_back: interpolation engine
// Steps through one run at a time, one interpolated row per cycle unless
// stalled, with an accumulator holding diff * k and a registered output stage.
// ---------------------------------------------------------------------------
module plu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  plu_pkg::t_run    i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output plu_pkg::t_sample o_out_x,
    output plu_pkg::t_sample o_out_y,
    output plu_pkg::t_sample o_out_z,
    output logic             o_run_last,
    output logic             o_sequence_end
);
    import plu_pkg::*;

    logic                          r_busy, n_busy;
    logic [K_W-1:0]                r_k;
    logic signed [ACC_W-1:0]       r_acc [NUM_CH];
    t_run                          r_run;
    logic                          r_out_valid, n_out_valid;
    t_sample [NUM_CH-1:0]          r_out, n_out;
    logic                          r_out_run_last;
    logic                          r_out_seq_end;
    logic                          advance;
    logic                          last_k;
    logic                          load;
    logic signed [ACC_W-1:0]       sum [NUM_CH];

    assign advance = r_busy && (!r_out_valid || !i_stall);
    assign last_k  = (r_k == K_W'(RATIO - 1));
    assign load    = (!r_busy || (advance && last_k)) && !i_empty;
    assign o_pop   = load;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            // arithmetic shift floors the scaled difference
            sum[c] = $signed({{(ACC_W-SAMPLE_W){r_run.base[c][SAMPLE_W-1]}}, r_run.base[c]})
                   + (r_acc[c] >>> RATIO_SHIFT);
            n_out[c] = sum[c][SAMPLE_W-1:0];
        end
        n_busy = r_busy;
        if (load) begin
            n_busy = 1'b1;
        end else if (advance && last_k) begin
            n_busy = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            if (load) begin
                r_k <= '0;
            end else if (advance) begin
                r_k <= r_k + K_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_run <= i_head;
            for (int c = 0; c < NUM_CH; c++) begin
                r_acc[c] <= '0;
            end
        end else if (advance) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_acc[c] <= r_acc[c]
                          + $signed({{(ACC_W-DIFF_W){r_run.diff[c][DIFF_W-1]}},
                                     r_run.diff[c]});
            end
        end
        if (advance) begin
            r_out          <= n_out;
            r_out_run_last <= r_run.run_end && last_k;
            r_out_seq_end  <= r_run.seq_end && last_k;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_x        = r_out[0];
    assign o_out_y        = r_out[1];
    assign o_out_z        = r_out[2];
    assign o_run_last     = r_out_run_last;
    assign o_sequence_end = r_out_seq_end;

`ifndef SYNTHESIS
    a_seq_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_seq_end) |-> r_out_run_last)
        else $error("sequence end without run end");
    a_stalled_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled output changed");
    a_idle_counter_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !load) |=> (!r_busy || r_k == '0))
        else $error("run started with nonzero step");
`endif

endmodule
